// ----- src/ordered_queue_with_delete_assert.svh -----
// ----------------------------------------------------------------------------
// ordered queue assertion macros
// shared property shapes for the queue checks, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef ORDERED_QUEUE_WITH_DELETE_ASSERT_SVH
`define ORDERED_QUEUE_WITH_DELETE_ASSERT_SVH

// same-cycle implication
`define OQD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered queue check failed");

// next-cycle implication
`define OQD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered queue check failed");

`endif

// ----- src/oqd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqd_pkg
// command and status codes and the cell control bundle of the ordered queue
// ----------------------------------------------------------------------------
package oqd_pkg;

	localparam logic [2:0] CMD_APPEND   = 3'd0;
	localparam logic [2:0] CMD_REMOVE   = 3'd1;
	localparam logic [2:0] CMD_CONTAINS = 3'd2;
	localparam logic [2:0] CMD_POP      = 3'd3;
	localparam logic [2:0] CMD_RESTART  = 3'd4;
	localparam logic [2:0] CMD_STEP     = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic cmp_en;
		logic valid;
		logic shift;
		logic write;
	} cell_ctl_t;

endpackage

// ----- src/oqd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oqd_cell
// one queue slot: holds an entry, compares it, takes the word behind it on a
// close-up and passes the first-match prefix to the next slot
// ----------------------------------------------------------------------------
module oqd_cell (
	input  logic              clk,
	input  oqd_pkg::cell_ctl_t ctl,
	input  logic [31:0]       cmp_value,
	input  logic [31:0]       wr_value,
	input  logic [31:0]       next_entry,
	input  logic              prefix_in,
	output logic [31:0]       entry,
	output logic              hit,
	output logic              prefix_out
);

	logic [31:0] entry_q;
	logic        hit_q;

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			entry_q <= wr_value;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	// match is sampled when the command is taken, masked to live slots
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			hit_q <= ctl.valid && (entry_q == cmp_value);
		end
	end

	assign entry      = entry_q;
	assign hit        = hit_q;
	assign prefix_out = prefix_in | hit_q;

endmodule

// ----- src/ordered_queue_with_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_queue_with_delete
// ordered queue of 32-bit words with remove by value, membership and walk
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The word is compared
// against all slots in the cycle it is taken, and the row of slots is shifted,
// written or read in the next cycle, during which busy is high. The result
// appears in the cycle after that for one cycle with done high and cannot be
// held off; a new command may be taken in that same cycle, but none is taken
// while one is still being carried out. size and walk_ended give the state
// after the command; result_value is 0 unless a word is popped or walked.
module ordered_queue_with_delete #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   cmd,
	input  logic [31:0]                  value,
	output logic                         done,
	output logic [31:0]                  result_value,
	output logic [1:0]                   status,
	output logic                         walk_ended,
	output logic [$clog2(DEPTH+1)-1:0]   size
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		IDLE = 2'b01,
		EXEC = 2'b10
	} state_t;

	state_t      state_q;
	logic [2:0]  cmd_q;
	logic [31:0] value_q;
	logic [CW-1:0] count_q, pos_q;
	logic          walk_done_q;

	logic [31:0]   ent [DEPTH];
	logic [DEPTH-1:0] hits, prefix;
	oqd_pkg::cell_ctl_t ctl [DEPTH];

	logic          accept, exec;
	logic          empty, full, any_hit, hit_last;
	logic [CW-1:0] cnt_m1, pos_p1;
	logic [CW-1:0] count_d, pos_d;
	logic          walk_done_d;
	logic [31:0]   res_d;
	logic [1:0]    st_d;
	logic          pop_go, rm_go, app_go;

	logic          done_q, ended_q;
	logic [31:0]   result_q;
	logic [1:0]    status_q;
	logic [CW-1:0] size_q;

	assign accept = start && (state_q == IDLE);
	assign exec   = (state_q == EXEC);

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign any_hit  = prefix[DEPTH-1];
	assign cnt_m1   = count_q - CW'(1);
	assign hit_last = hits[cnt_m1[IW-1:0]];
	assign pos_p1   = pos_q + CW'(1);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			assign ctl[i].cmp_en = accept;
			assign ctl[i].valid  = (CW'(i) < count_q);
			// close up behind the removed word; a back hit with no head hit needs no move
			assign ctl[i].shift  = exec && (pop_go ||
				(rm_go && !(hit_last && !hits[0]) && prefix[i]));
			assign ctl[i].write  = exec && app_go && (count_q == CW'(i));

			if (i == 0) begin : g_head
				oqd_cell u_cell (
					.clk        (clk),
					.ctl        (ctl[i]),
					.cmp_value  (value),
					.wr_value   (value_q),
					.next_entry (ent[i+1]),
					.prefix_in  (1'b0),
					.entry      (ent[i]),
					.hit        (hits[i]),
					.prefix_out (prefix[i])
				);
			end else if (i == DEPTH - 1) begin : g_tail
				oqd_cell u_cell (
					.clk        (clk),
					.ctl        (ctl[i]),
					.cmp_value  (value),
					.wr_value   (value_q),
					.next_entry (ent[i]),
					.prefix_in  (prefix[i-1]),
					.entry      (ent[i]),
					.hit        (hits[i]),
					.prefix_out (prefix[i])
				);
			end else begin : g_mid
				oqd_cell u_cell (
					.clk        (clk),
					.ctl        (ctl[i]),
					.cmp_value  (value),
					.wr_value   (value_q),
					.next_entry (ent[i+1]),
					.prefix_in  (prefix[i-1]),
					.entry      (ent[i]),
					.hit        (hits[i]),
					.prefix_out (prefix[i])
				);
			end
		end
	endgenerate

	always_comb begin
		count_d     = count_q;
		pos_d       = pos_q;
		walk_done_d = walk_done_q;
		res_d       = '0;
		st_d        = oqd_pkg::ST_OK;
		pop_go      = 1'b0;
		rm_go       = 1'b0;
		app_go      = 1'b0;
		case (cmd_q)
			oqd_pkg::CMD_APPEND: begin
				if (full) begin
					st_d = oqd_pkg::ST_FULL;
				end else begin
					app_go  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			oqd_pkg::CMD_REMOVE: begin
				if (any_hit) begin
					rm_go   = 1'b1;
					count_d = cnt_m1;
				end else begin
					st_d = oqd_pkg::ST_NOT_FOUND;
				end
			end
			oqd_pkg::CMD_CONTAINS: begin
				st_d = any_hit ? oqd_pkg::ST_OK : oqd_pkg::ST_NOT_FOUND;
			end
			oqd_pkg::CMD_POP: begin
				if (empty) begin
					st_d = oqd_pkg::ST_EMPTY;
				end else begin
					res_d   = ent[0];
					pop_go  = 1'b1;
					count_d = cnt_m1;
				end
			end
			oqd_pkg::CMD_RESTART: begin
				pos_d = '0;
				if (empty) begin
					walk_done_d = 1'b1;
					st_d        = oqd_pkg::ST_EMPTY;
				end else begin
					walk_done_d = 1'b0;
					res_d       = ent[0];
				end
			end
			oqd_pkg::CMD_STEP: begin
				if (walk_done_q || (pos_q >= count_q)) begin
					walk_done_d = 1'b1;
					st_d        = oqd_pkg::ST_NOT_FOUND;
				end else begin
					pos_d = pos_p1;
					if (pos_p1 < count_q) begin
						res_d = ent[pos_p1[IW-1:0]];
					end else begin
						walk_done_d = 1'b1;
						st_d        = oqd_pkg::ST_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			walk_done_q <= 1'b1;
			done_q      <= 1'b0;
		end else begin
			done_q <= exec;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					state_q     <= IDLE;
					count_q     <= count_d;
					pos_q       <= pos_d;
					walk_done_q <= walk_done_d;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			value_q <= value;
		end
		if (exec) begin
			result_q <= res_d;
			status_q <= st_d;
			ended_q  <= walk_done_d || (pos_d >= count_d);
			size_q   <= count_d;
		end
	end

	assign busy         = (state_q != IDLE);
	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign walk_ended   = ended_q;
	assign size         = size_q;

`include "ordered_queue_with_delete_assert.svh"

	`OQD_ASSERT_NEXT(a_take_goes_busy, start && !busy, busy && !done)
	`OQD_ASSERT_NEXT(a_exec_gives_word, busy, done && !busy)
	`OQD_ASSERT_IMP(a_size_bound, done, size <= CW'(DEPTH))
	`OQD_ASSERT_IMP(a_drop_only_full, done && (status == oqd_pkg::ST_FULL), size == CW'(DEPTH))

endmodule
